// File: rtl/lomb_pkg.sv
// Shared types, constants and setup states for the look-at / ortho matrix builder.
// No dependencies; imported by lomb_setup and lookat_ortho_matrix_builder.
`default_nettype none
package lomb_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_DIR_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DIR_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DIR_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BACK   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ORTHO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEPTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd6;

  localparam logic [30:0]        BACK_RST   = 31'd3276800;
  localparam logic [30:0]        ORTHO_RST  = 31'd107374182;
  localparam logic [30:0]        DEPTH_RST  = 31'd10737429;
  localparam logic signed [31:0] OFFSET_RST = -32'sd1074;

  localparam logic signed [47:0] MAX48 = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  typedef logic signed [31:0] ax_t;
  typedef ax_t [2:0][2:0]     axm_t;
  typedef logic signed [47:0] m_t;
  typedef m_t [2:0][2:0]      colm_t;
  typedef logic signed [63:0] w64_t;
  typedef w64_t [2:0]         vec64_t;
  typedef logic signed [31:0] d32_t;
  typedef d32_t [2:0]         dirv_t;

  typedef struct packed {
    dirv_t       dir;
    logic [30:0] back;
    logic [30:0] ortho;
    logic [30:0] depth;
  } cfg_t;

  typedef struct packed {
    logic   busy;
    axm_t   ax;
    colm_t  col;
    vec64_t bd;
  } setup_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_NMAG,
    S_NSHIFT,
    S_NSQ,
    S_NSQRT,
    S_NDINIT,
    S_NDIV,
    S_NDONE,
    S_CROSS,
    S_SCALE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/lomb_setup.sv
// Sequential setup unit: normalizes the camera axes and precomputes the
// configuration-only terms (scaled axis columns, back_distance * dir). Uses lomb_pkg.
`default_nettype none
module lomb_setup (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            restart,
  input  wire lomb_pkg::cfg_t  cfg,
  output lomb_pkg::setup_t     res
);
  import lomb_pkg::*;

  state_t state, state_next;
  logic [1:0]  dst;
  logic [3:0]  k;
  logic [4:0]  cnt;
  vec64_t      nv;
  logic [63:0] nm [3];
  logic [63:0] acc;
  logic [63:0] sr;
  logic [63:0] sbit;
  logic [30:0] len;
  logic [31:0] nl;
  logic [31:0] rem;
  logic [31:0] q;
  axm_t        ax;
  colm_t       col;
  vec64_t      bd;

  logic [63:0]        mx;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [65:0]        pmag;
  logic [65:0]        prnd;
  logic signed [47:0] colv;
  logic [1:0]         sel_r, sel_c;
  logic [63:0]        rb, sx_n, sr_n;
  logic               sge;
  logic [32:0]        rem2;
  logic               dge;
  logic [31:0]        rem_n, q_n;
  logic signed [31:0] axv;
  logic [60:0]        numv;

  always_comb begin
    mx = nm[0];
    if (nm[1] > mx) mx = nm[1];
    if (nm[2] > mx) mx = nm[2];
  end

  always_comb begin
    sel_r = 2'd0;
    sel_c = 2'd0;
    case (k)
      4'd0:    begin sel_r = 2'd0; sel_c = 2'd0; end
      4'd1:    begin sel_r = 2'd0; sel_c = 2'd1; end
      4'd2:    begin sel_r = 2'd0; sel_c = 2'd2; end
      4'd3:    begin sel_r = 2'd1; sel_c = 2'd0; end
      4'd4:    begin sel_r = 2'd1; sel_c = 2'd1; end
      4'd5:    begin sel_r = 2'd1; sel_c = 2'd2; end
      4'd6:    begin sel_r = 2'd2; sel_c = 2'd0; end
      4'd7:    begin sel_r = 2'd2; sel_c = 2'd1; end
      4'd8:    begin sel_r = 2'd2; sel_c = 2'd2; end
      4'd9:    begin sel_r = 2'd3; sel_c = 2'd0; end
      4'd10:   begin sel_r = 2'd3; sel_c = 2'd1; end
      4'd11:   begin sel_r = 2'd3; sel_c = 2'd2; end
      default: begin sel_r = 2'd3; sel_c = 2'd2; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NSQ: begin
        mul_a = {3'b0, nm[k[1:0]][29:0]};
        mul_b = {3'b0, nm[k[1:0]][29:0]};
      end
      S_CROSS: begin
        case (k)
          4'd0:    begin mul_a = 33'(ax[0][1]); mul_b = 33'(ax[2][2]); end
          4'd1:    begin mul_a = 33'(ax[0][2]); mul_b = 33'(ax[2][1]); end
          4'd2:    begin mul_a = 33'(ax[0][2]); mul_b = 33'(ax[2][0]); end
          4'd3:    begin mul_a = 33'(ax[0][0]); mul_b = 33'(ax[2][2]); end
          4'd4:    begin mul_a = 33'(ax[0][0]); mul_b = 33'(ax[2][1]); end
          default: begin mul_a = 33'(ax[0][1]); mul_b = 33'(ax[2][0]); end
        endcase
      end
      S_SCALE: begin
        case (sel_r)
          2'd0, 2'd1: begin
            mul_a = {2'b0, cfg.ortho};
            mul_b = 33'(ax[sel_r][sel_c]);
          end
          2'd2: begin
            mul_a = {2'b0, cfg.depth};
            mul_b = 33'(ax[sel_r][sel_c]);
          end
          default: begin
            mul_a = {2'b0, cfg.back};
            mul_b = 33'(cfg.dir[sel_c]);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign pmag = prod[65] ? 66'(-prod) : 66'(prod);
  assign prnd = (pmag + 66'd134217728) >> 28;
  assign colv = prod[65] ? -48'(signed'(prnd[47:0])) : 48'(signed'(prnd[47:0]));

  assign rb   = sr + sbit;
  assign sge  = acc >= rb;
  assign sx_n = sge ? acc - rb : acc;
  assign sr_n = sge ? (sr >> 1) + sbit : sr >> 1;

  assign rem2  = {rem, nl[31]};
  assign dge   = rem2 >= {2'b0, len};
  assign rem_n = dge ? 32'(rem2 - {2'b0, len}) : rem2[31:0];
  assign q_n   = {q[30:0], dge};
  assign axv   = nv[k[1:0]][63] ? -signed'(q_n) : signed'(q_n);
  assign numv  = {nm[k[1:0]][30:0], 30'b0} + {31'b0, len[30:1]};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   state_next = S_IDLE;
      S_START:  state_next = S_NMAG;
      S_NMAG:   state_next = S_NSHIFT;
      S_NSHIFT: begin
        if (mx == 64'd0) begin
          state_next = S_NDONE;
        end else if (mx < 64'h4000_0000 && mx >= 64'h2000_0000) begin
          state_next = S_NSQ;
        end
      end
      S_NSQ:    if (k == 4'd2) state_next = S_NSQRT;
      S_NSQRT:  if (cnt == 5'd31) state_next = S_NDINIT;
      S_NDINIT: state_next = S_NDIV;
      S_NDIV: begin
        if (cnt == 5'd31) state_next = (k == 4'd2) ? S_NDONE : S_NDINIT;
      end
      S_NDONE: begin
        case (dst)
          2'd2:    state_next = S_NMAG;
          2'd0:    state_next = S_CROSS;
          default: state_next = S_SCALE;
        endcase
      end
      S_CROSS:  if (k == 4'd5) state_next = S_NMAG;
      S_SCALE:  if (k == 4'd11) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
    if (restart) state_next = S_START;
  end

  always_comb begin
    res.busy = state != S_IDLE;
    res.ax   = ax;
    res.col  = col;
    res.bd   = bd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_START: begin
        dst <= 2'd2;
        for (int i = 0; i < 3; i++) nv[i] <= 64'(cfg.dir[i]);
      end
      S_NMAG: begin
        for (int i = 0; i < 3; i++) nm[i] <= nv[i][63] ? 64'(-nv[i]) : 64'(nv[i]);
      end
      S_NSHIFT: begin
        k   <= 4'd0;
        acc <= 64'd0;
        if (mx == 64'd0) begin
          for (int i = 0; i < 3; i++) ax[dst][i] <= '0;
        end else if (mx >= 64'h4000_0000) begin
          for (int i = 0; i < 3; i++) nm[i] <= nm[i] >> 1;
        end else if (mx < 64'h2000_0000) begin
          for (int i = 0; i < 3; i++) nm[i] <= nm[i] << 1;
        end
      end
      S_NSQ: begin
        acc <= acc + prod[63:0];
        k   <= k + 4'd1;
        sr   <= 64'd0;
        sbit <= 64'h4000_0000_0000_0000;
        cnt  <= 5'd0;
      end
      S_NSQRT: begin
        acc  <= sx_n;
        sr   <= sr_n;
        sbit <= sbit >> 2;
        cnt  <= cnt + 5'd1;
        len  <= sr_n[30:0];
        k    <= 4'd0;
      end
      S_NDINIT: begin
        nl  <= numv[31:0];
        rem <= {3'b0, numv[60:32]};
        q   <= 32'd0;
        cnt <= 5'd0;
      end
      S_NDIV: begin
        rem <= rem_n;
        q   <= q_n;
        nl  <= nl << 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          ax[dst][k[1:0]] <= axv;
          k <= k + 4'd1;
        end
      end
      S_NDONE: begin
        k <= 4'd0;
        case (dst)
          2'd2: begin
            dst   <= 2'd0;
            nv[0] <= 64'd0;
            nv[1] <= 64'(ax[2][2]);
            nv[2] <= -64'(ax[2][1]);
          end
          2'd0: begin
            for (int i = 0; i < 3; i++) nv[i] <= 64'd0;
          end
          default: dst <= dst;
        endcase
      end
      S_CROSS: begin
        if (k[0]) nv[k[2:1]] <= nv[k[2:1]] - prod[63:0];
        else      nv[k[2:1]] <= nv[k[2:1]] + prod[63:0];
        k <= k + 4'd1;
        if (k == 4'd5) dst <= 2'd1;
      end
      S_SCALE: begin
        if (sel_r == 2'd3) bd[sel_c] <= prod[63:0];
        else               col[sel_r][sel_c] <= colv;
        k <= k + 4'd1;
      end
      default: k <= k;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/lookat_ortho_matrix_builder.sv
// Top level: configuration registers, setup unit and the per-centre pipeline.
// Depends on lomb_pkg and lomb_setup.
//
// Use: write the light direction, back distance and projection scales on the
// cfg channel (index = register number, data in cfg_data). Each write makes the
// setup unit renormalize the axes; while it runs s_axis_tready stays low. The
// setup pass is shortest for a zero direction and is otherwise governed by
// the bit-serial square root, the one-bit-per-cycle divider and
// the one-bit-per-cycle block shift that normalize each of the three axes.
// After reset the same pass runs once with the reset register values.
// Each request on s_axis carries one scene centre; one matrix (rows 0..2)
// leaves on m_axis for each, through the registered pipeline stages. One request
// is taken every cycle while no setup pass runs. A stalled m_axis_tready holds
// every pipeline stage in place and drops s_axis_tready; nothing is lost or
// repeated. Reset clears all valid bits and restores the register defaults.
`default_nettype none
module lookat_ortho_matrix_builder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // centre_x, centre_y, centre_z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [575:0]      m_axis_tdata,   // m00 m01 m02 m03 m10 .. m13 m20 .. m23
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [lomb_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import lomb_pkg::*;

  cfg_t               cfg;
  logic signed [31:0] offset;
  setup_t             su;
  logic               cfg_wr;
  logic               en;

  logic [6:1]         v;
  vec64_t             neye;
  logic [63:0]        pl [3][3];
  logic [63:0]        ph [3][3];
  logic               sg [3][3];
  logic [63:0]        pl_c [3][3];
  logic [63:0]        ph_c [3][3];
  logic               sg_c [3][3];
  logic signed [63:0] term [3][3];
  logic signed [63:0] term_c [3][3];
  logic signed [63:0] trans [3];
  logic [63:0]        spl [3];
  logic [63:0]        sph [3];
  logic               sneg [3];
  logic [63:0]        spl_c [3];
  logic [63:0]        sph_c [3];
  logic               sneg_c [3];
  logic signed [47:0] t48 [3];
  logic signed [47:0] t48_c [3];
  logic signed [47:0] mout [3];
  logic signed [49:0] sum50;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir   <= '0;
      cfg.back  <= BACK_RST;
      cfg.ortho <= ORTHO_RST;
      cfg.depth <= DEPTH_RST;
      offset    <= OFFSET_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_DIR_X:  cfg.dir[0] <= cfg_data;
        REG_DIR_Y:  cfg.dir[1] <= cfg_data;
        REG_DIR_Z:  cfg.dir[2] <= cfg_data;
        REG_BACK:   cfg.back   <= cfg_data[30:0];
        REG_ORTHO:  cfg.ortho  <= cfg_data[30:0];
        REG_DEPTH:  cfg.depth  <= cfg_data[30:0];
        REG_OFFSET: offset     <= cfg_data;
        default:    offset     <= offset;
      endcase
    end
  end

  lomb_setup u_setup (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .cfg     (cfg),
    .res     (su)
  );

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !su.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v             <= {v[5:1], s_axis_tvalid & s_axis_tready};
      m_axis_tvalid <= v[6];
    end
  end

  // stage 2 partial products: |axis| times low and high halves of |neye|
  always_comb begin
    logic [63:0] nmag;
    logic [31:0] amag;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nmag = neye[c][63] ? 64'(-neye[c]) : 64'(neye[c]);
        amag = su.ax[r][c][31] ? 32'(-su.ax[r][c]) : 32'(su.ax[r][c]);
        pl_c[r][c] = amag * nmag[31:0];
        ph_c[r][c] = amag * nmag[63:32];
        sg_c[r][c] = su.ax[r][c][31] ^ neye[c][63];
      end
    end
  end

  // stage 3 round half away from zero, shift by 32
  always_comb begin
    logic [95:0] full;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        full = {ph[r][c], 32'b0} + {32'b0, pl[r][c]} + 96'h8000_0000;
        term_c[r][c] = sg[r][c] ? -signed'(full[95:32]) : signed'(full[95:32]);
      end
    end
  end

  // stage 5 scale partial products
  always_comb begin
    logic [63:0] tmag;
    logic [30:0] s;
    for (int r = 0; r < 3; r++) begin
      tmag = trans[r][63] ? 64'(-trans[r]) : 64'(trans[r]);
      s = (r == 2) ? cfg.depth : cfg.ortho;
      spl_c[r]  = 64'(s * tmag[31:0]);
      sph_c[r]  = 64'(s * tmag[63:32]);
      sneg_c[r] = trans[r][63];
    end
  end

  // stage 6 round, shift by 28, saturate to 48 bits
  always_comb begin
    logic [95:0] full;
    logic [67:0] mg;
    for (int r = 0; r < 3; r++) begin
      full = {sph[r], 32'b0} + {32'b0, spl[r]} + 96'd134217728;
      mg   = full[95:28];
      if (sneg[r]) begin
        t48_c[r] = (mg > 68'h8000_0000_0000) ? MIN48 : -signed'(mg[47:0]);
      end else begin
        t48_c[r] = (mg > 68'h7fff_ffff_ffff) ? MAX48 : signed'(mg[47:0]);
      end
    end
  end

  assign sum50 = {{2{t48[2][47]}}, t48[2]} + {{16{offset[31]}}, offset, 2'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neye[c] <= su.bd[c] - {{16{s_axis_tdata[32*c+31]}}, s_axis_tdata[32*c +: 32], 16'b0};
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pl[r][c]   <= pl_c[r][c];
          ph[r][c]   <= ph_c[r][c];
          sg[r][c]   <= sg_c[r][c];
          term[r][c] <= term_c[r][c];
        end
        trans[r] <= term[r][0] + term[r][1] + term[r][2];
        spl[r]   <= spl_c[r];
        sph[r]   <= sph_c[r];
        sneg[r]  <= sneg_c[r];
        t48[r]   <= t48_c[r];
      end
      mout[0] <= t48[0];
      mout[1] <= t48[1];
      if (sum50 > 50'(MAX48))      mout[2] <= MAX48;
      else if (sum50 < 50'(MIN48)) mout[2] <= MIN48;
      else                         mout[2] <= sum50[47:0];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_axis_tdata[192*r + 48*c +: 48] = su.col[r][c];
      end
      m_axis_tdata[192*r + 144 +: 48] = mout[r];
    end
  end

endmodule
`default_nettype wire
